FILE: rtl/i2c_master_transfer_sequencer_unit_assert.svh
// assertion macros shared by the sequencer rtl
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define I2CSEQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define I2CSEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/i2cseq_pkg.sv
`default_nettype none

package i2cseq_pkg;

    // write buffer geometry
    localparam int BUF_DEPTH = 256;
    localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    // input modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_IRQ   = 2'd1;
    localparam logic [1:0] MODE_LOAD  = 2'd2;

    // controller status codes
    localparam logic [7:0] ST_START_SENT = 8'h08;
    localparam logic [7:0] ST_WA_ACK     = 8'h18;
    localparam logic [7:0] ST_WA_NACK    = 8'h20;
    localparam logic [7:0] ST_WD_ACK     = 8'h28;
    localparam logic [7:0] ST_RA_ACK     = 8'h40;
    localparam logic [7:0] ST_RA_NACK    = 8'h48;
    localparam logic [7:0] ST_RD_ACK     = 8'h50;
    localparam logic [7:0] ST_RD_NACK    = 8'h58;

    // control register bits
    localparam logic [7:0] CTL_AA  = 8'h80;
    localparam logic [7:0] CTL_STA = 8'h20;
    localparam logic [7:0] CTL_STO = 8'h10;
    localparam logic [7:0] CTL_SI  = 8'h08;

    // result codes
    localparam logic [1:0] RES_OK       = 2'd0;
    localparam logic [1:0] RES_NO_REPLY = 2'd1;
    localparam logic [1:0] RES_BUSY     = 2'd2;

    typedef enum logic [1:0] {
        OP_IDLE = 2'd0,
        OP_READ = 2'd1,
        OP_SEND = 2'd2
    } op_t;

    // item fields needed once the buffer read is done
    typedef struct packed {
        logic [1:0] mode;
        logic       read_not_write;
        logic [6:0] slave_address;
        logic [8:0] transfer_length;
        logic       interrupt_pending;
        logic [7:0] status_code;
        logic [7:0] control_now;
        logic [7:0] data_now;
    } item_t;

    typedef struct packed {
        op_t        operation;
        logic [7:0] address_byte;
        logic [8:0] length_left;
        logic [8:0] byte_count;
    } state_t;

    typedef struct packed {
        logic [1:0] result_code;
        logic       done_res;
        logic [7:0] received_index;
        logic [7:0] received_byte;
        logic       received_valid;
        logic [7:0] data_value;
        logic       data_write;
        logic [7:0] control_value;
        logic       control_write;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/i2cseq_buf_ram.sv
`default_nettype none

module i2cseq_buf_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 8
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [DW-1:0] rdata_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/i2cseq_step.sv
`default_nettype none

module i2cseq_step
    import i2cseq_pkg::*;
(
    input  wire item_t      item,
    input  wire state_t     state,
    input  wire logic [7:0] buf_byte,
    output result_t         res,
    output state_t          state_next
);

    logic [8:0] bc_inc;
    logic [8:0] bc_eff;
    logic [7:0] ctl_v;

    assign bc_inc = 9'(state.byte_count + 9'd1);

    // status decode for one item
    always_comb
    begin
        res        = '0;
        state_next = state;
        bc_eff     = state.byte_count;
        ctl_v      = '0;

        if (item.mode == MODE_START)
        begin
            state_next.operation    = item.read_not_write ? OP_READ : OP_SEND;
            state_next.address_byte = {item.slave_address, item.read_not_write};
            state_next.length_left  = item.transfer_length;
            state_next.byte_count   = '0;
            res.control_write       = 1'b1;
            res.control_value       = item.control_now | CTL_STA | CTL_AA;
        end
        else if (item.mode == MODE_IRQ && item.interrupt_pending)
        begin
            res.control_write = 1'b1;
            unique case (state.operation)
                OP_READ:
                begin
                    case (item.status_code) inside
                        ST_START_SENT:
                        begin
                            res.data_write    = 1'b1;
                            res.data_value    = state.address_byte;
                            res.control_value = item.control_now & ~(CTL_SI | CTL_STA);
                        end
                        ST_RA_ACK, ST_RD_ACK:
                        begin
                            // a data byte arrived: capture and count it first
                            if (item.status_code == ST_RD_ACK)
                            begin
                                res.received_valid    = 1'b1;
                                res.received_byte     = item.data_now;
                                res.received_index    = state.byte_count[7:0];
                                bc_eff                = bc_inc;
                                state_next.byte_count = bc_inc;
                            end
                            ctl_v = item.control_now & ~CTL_SI;
                            // acknowledge unless the next byte is the last one
                            if (({1'b0, bc_eff} + 10'd1) < {1'b0, state.length_left})
                            begin
                                ctl_v = ctl_v | CTL_AA;
                            end
                            else
                            begin
                                ctl_v = ctl_v & ~CTL_AA;
                            end
                            res.control_value = ctl_v;
                        end
                        ST_RA_NACK:
                        begin
                            res.control_value = (item.control_now & ~CTL_SI) | CTL_STO;
                            res.done_res      = 1'b1;
                            res.result_code   = RES_NO_REPLY;
                        end
                        ST_RD_NACK:
                        begin
                            res.received_valid    = 1'b1;
                            res.received_byte     = item.data_now;
                            res.received_index    = state.byte_count[7:0];
                            state_next.byte_count = bc_inc;
                            res.control_value     = (item.control_now & ~CTL_SI)
                                                    | CTL_AA | CTL_STO;
                            res.done_res          = 1'b1;
                            res.result_code       = RES_OK;
                        end
                        default:
                        begin
                            res.control_value = '0;
                            res.done_res      = 1'b1;
                            res.result_code   = RES_BUSY;
                        end
                    endcase
                end
                OP_SEND:
                begin
                    case (item.status_code) inside
                        ST_START_SENT:
                        begin
                            res.data_write    = 1'b1;
                            res.data_value    = state.address_byte;
                            res.control_value = item.control_now & ~(CTL_SI | CTL_STA);
                        end
                        ST_WA_ACK, ST_WD_ACK:
                        begin
                            // a data ack counts the byte just sent
                            if (item.status_code == ST_WD_ACK)
                            begin
                                bc_eff                = bc_inc;
                                state_next.byte_count = bc_inc;
                                ctl_v                 = item.control_now & ~CTL_SI;
                            end
                            else
                            begin
                                ctl_v = item.control_now & ~(CTL_SI | CTL_STA);
                            end
                            if (bc_eff < state.length_left)
                            begin
                                res.data_write = 1'b1;
                                res.data_value = buf_byte;
                            end
                            else
                            begin
                                ctl_v = ctl_v | CTL_STO;
                            end
                            res.control_value = ctl_v;
                            if (bc_eff == state.length_left)
                            begin
                                res.done_res    = 1'b1;
                                res.result_code = RES_OK;
                            end
                        end
                        ST_WA_NACK:
                        begin
                            res.control_value = (item.control_now & ~CTL_SI) | CTL_STO;
                            res.done_res      = 1'b1;
                            res.result_code   = RES_NO_REPLY;
                        end
                        default:
                        begin
                            res.control_value = '0;
                            res.done_res      = 1'b1;
                            res.result_code   = RES_BUSY;
                        end
                    endcase
                end
                default:
                begin
                    // interrupt with no transfer running
                    res.control_value = '0;
                    res.done_res      = 1'b1;
                    res.result_code   = RES_OK;
                end
            endcase

            // end of transfer
            if (res.done_res)
            begin
                state_next.operation    = OP_IDLE;
                state_next.address_byte = '0;
                state_next.length_left  = '0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/i2c_master_transfer_sequencer_unit.sv
// an accepted item is registered in the decode stage, then its result in the output register
// throughput: one item per cycle unless m_tready stalls; the decode stage item's byte count is
//   forwarded into the write buffer read address, so a following item never waits on it
// reset: rst_n clears transfer state, stage and output valid asynchronously;
//   write buffer contents stay undefined until loaded, no clearing pass
`default_nettype none
`include "i2c_master_transfer_sequencer_unit_assert.svh"

module i2c_master_transfer_sequencer_unit
    import i2cseq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // read_not_write, slave_address, transfer_length, buffer_index, buffer_byte,
    // interrupt_pending, status_code, control_now, data_now
    input  wire logic [63:0] s_tdata,
    // mode
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // control_write, control_value, data_write, data_value, received_valid,
    // received_byte, received_index, done_res, result_code
    output logic [39:0]      m_tdata
);

    item_t              in_item;
    logic [7:0]         in_buffer_index;
    logic [7:0]         in_buffer_byte;
    logic               s_accept;
    logic               stage_advance;

    logic               stage_valid_reg;
    item_t              stage_item_reg;
    logic               out_valid_reg;
    result_t            out_res_reg;
    state_t             state_reg;

    result_t            step_res;
    state_t             step_state;
    logic [7:0]         buf_rdata;
    logic [8:0]         bc_fwd;
    logic [8:0]         rd_count;
    logic               buf_we;

    // unpack the input item
    assign in_item.mode              = s_tuser;
    assign in_item.read_not_write    = s_tdata[0];
    assign in_item.slave_address     = s_tdata[7:1];
    assign in_item.transfer_length   = s_tdata[16:8];
    assign in_buffer_index           = s_tdata[24:17];
    assign in_buffer_byte            = s_tdata[32:25];
    assign in_item.interrupt_pending = s_tdata[33];
    assign in_item.status_code       = s_tdata[41:34];
    assign in_item.control_now       = s_tdata[49:42];
    assign in_item.data_now          = s_tdata[57:50];

    // handshake: decode stage drains into the output register
    assign stage_advance = stage_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready      = !stage_valid_reg || stage_advance;
    assign s_accept      = s_tvalid && s_tready;

    // byte count as it stands once the decode stage item commits
    assign bc_fwd   = stage_valid_reg ? step_state.byte_count : state_reg.byte_count;
    assign rd_count = (in_item.status_code == ST_WD_ACK) ? 9'(bc_fwd + 9'd1) : bc_fwd;
    assign buf_we   = s_accept && (in_item.mode == MODE_LOAD)
                      && (int'(in_buffer_index) < BUF_DEPTH);

    i2cseq_buf_ram #(
        .DEPTH (BUF_DEPTH),
        .AW    (BUF_AW),
        .DW    (8)
    ) u_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (in_buffer_index[BUF_AW-1:0]),
        .wdata (in_buffer_byte),
        .re    (s_accept),
        .raddr (rd_count[BUF_AW-1:0]),
        .rdata (buf_rdata)
    );

    i2cseq_step u_step (
        .item       (stage_item_reg),
        .state      (state_reg),
        .buf_byte   (buf_rdata),
        .res        (step_res),
        .state_next (step_state)
    );

    // control and transfer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= '{operation: OP_IDLE, default: '0};
        end
        else
        begin
            if (s_accept)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (stage_advance)
            begin
                stage_valid_reg <= 1'b0;
            end

            if (stage_advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= step_state;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            stage_item_reg <= in_item;
        end
        if (stage_advance)
        begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg};

    `I2CSEQ_ASSERT_NOW(a_stall_blocks_input,
        stage_valid_reg && out_valid_reg && !m_tready, !s_tready,
        "input taken while decode stage is stalled")

    `I2CSEQ_ASSERT_NEXT(a_done_goes_idle,
        stage_advance && step_res.done_res, state_reg.operation == OP_IDLE,
        "transfer state not idle after finish")

    `I2CSEQ_ASSERT_NOW(a_idle_is_clear,
        state_reg.operation == OP_IDLE,
        state_reg.length_left == 9'd0 && state_reg.address_byte == 8'd0,
        "idle with stale transfer state")

    `I2CSEQ_ASSERT_NOW(a_done_has_control,
        out_valid_reg && out_res_reg.done_res,
        out_res_reg.control_write && !(out_res_reg.received_valid && out_res_reg.data_write),
        "finish without control write or capture with data write")

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import i2cseq_pkg::*;

    // one stimulus item, mode kept beside the tdata fields
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_now;
        logic [7:0] control_now;
        logic [7:0] status_code;
        logic       interrupt_pending;
        logic [7:0] buffer_byte;
        logic [7:0] buffer_index;
        logic [8:0] transfer_length;
        logic [6:0] slave_address;
        logic       read_not_write;
    } seq_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // read_not_write, slave_address, transfer_length, buffer_index, buffer_byte,
    // interrupt_pending, status_code, control_now, data_now
    logic [63:0] s_tdata = '0;
    // mode
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // control_write, control_value, data_write, data_value, received_valid,
    // received_byte, received_index, done_res, result_code
    logic [39:0] m_tdata;

    seq_item_t pending_items[$];
    result_t   expected_results[$];
    seq_item_t cur_item;
    seq_item_t dir_item;
    result_t   got_result;
    result_t   want_result;
    int        items_queued = 0;
    int        error_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    // sequencer state mirror
    op_t        seq_op = OP_IDLE;
    logic [7:0] seq_addr_byte = '0;
    logic [8:0] seq_len = '0;
    logic [8:0] seq_count = '0;
    logic [7:0] tx_buffer [BUF_DEPTH];

    i2c_master_transfer_sequencer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock, 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // end of transfer: back to idle, address and length cleared
    function automatic void end_transfer(ref result_t r, input logic [1:0] code);
        r.done_res = 1'b1;
        r.result_code = code;
        seq_op = OP_IDLE;
        seq_addr_byte = '0;
        seq_len = '0;
    endfunction

    // received byte captured and counted
    function automatic void capture_byte(ref result_t r, input logic [7:0] data);
        r.received_valid = 1'b1;
        r.received_byte = data;
        r.received_index = seq_count[7:0];
        seq_count = seq_count + 9'd1;
    endfunction

    // expected result of one item, updates the state mirror
    function automatic result_t sequence_step(input seq_item_t it);
        result_t    r;
        logic [7:0] c;
        logic [7:0] v;
        r = '0;
        c = it.control_now;
        case (it.mode)
            MODE_START:
            begin
                seq_op = it.read_not_write ? OP_READ : OP_SEND;
                seq_addr_byte = {it.slave_address, it.read_not_write};
                seq_len = it.transfer_length;
                seq_count = '0;
                r.control_write = 1'b1;
                r.control_value = c | CTL_STA | CTL_AA;
            end
            MODE_IRQ:
            begin
                if (it.interrupt_pending)
                begin
                    r.control_write = 1'b1;
                    if (seq_op == OP_READ)
                    begin
                        case (it.status_code)
                            ST_START_SENT:
                            begin
                                r.data_write = 1'b1;
                                r.data_value = seq_addr_byte;
                                r.control_value = c & ~(CTL_SI | CTL_STA);
                            end
                            ST_RA_ACK, ST_RD_ACK:
                            begin
                                if (it.status_code == ST_RD_ACK)
                                    capture_byte(r, it.data_now);
                                v = c & ~CTL_SI;
                                // acknowledge only while more than one byte remains
                                if ({1'b0, seq_count} + 10'd1 < {1'b0, seq_len})
                                    v = v | CTL_AA;
                                else
                                    v = v & ~CTL_AA;
                                r.control_value = v;
                            end
                            ST_RA_NACK:
                            begin
                                r.control_value = (c & ~CTL_SI) | CTL_STO;
                                end_transfer(r, RES_NO_REPLY);
                            end
                            ST_RD_NACK:
                            begin
                                capture_byte(r, it.data_now);
                                r.control_value = (c & ~CTL_SI) | CTL_AA | CTL_STO;
                                end_transfer(r, RES_OK);
                            end
                            default:
                            begin
                                r.control_value = '0;
                                end_transfer(r, RES_BUSY);
                            end
                        endcase
                    end
                    else if (seq_op == OP_SEND)
                    begin
                        case (it.status_code)
                            ST_START_SENT:
                            begin
                                r.data_write = 1'b1;
                                r.data_value = seq_addr_byte;
                                r.control_value = c & ~(CTL_SI | CTL_STA);
                            end
                            ST_WA_ACK, ST_WD_ACK:
                            begin
                                if (it.status_code == ST_WD_ACK)
                                begin
                                    seq_count = seq_count + 9'd1;
                                    v = c & ~CTL_SI;
                                end
                                else
                                    v = c & ~(CTL_SI | CTL_STA);
                                // next byte while any remain, otherwise stop
                                if (seq_count < seq_len)
                                begin
                                    r.data_write = 1'b1;
                                    r.data_value = tx_buffer[seq_count[7:0]];
                                end
                                else
                                    v = v | CTL_STO;
                                r.control_value = v;
                                if (seq_count == seq_len)
                                    end_transfer(r, RES_OK);
                            end
                            ST_WA_NACK:
                            begin
                                r.control_value = (c & ~CTL_SI) | CTL_STO;
                                end_transfer(r, RES_NO_REPLY);
                            end
                            default:
                            begin
                                r.control_value = '0;
                                end_transfer(r, RES_BUSY);
                            end
                        endcase
                    end
                    else
                    begin
                        // interrupt with no transfer running
                        r.control_value = '0;
                        end_transfer(r, RES_OK);
                    end
                end
            end
            MODE_LOAD:
                tx_buffer[it.buffer_index] = it.buffer_byte;
            default:
                r = '0;
        endcase
        return r;
    endfunction

    // fully random item, any mode
    function automatic seq_item_t random_item();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[59:0];
    endfunction

    function automatic seq_item_t start_item(input logic rnw, input logic [6:0] addr,
                                             input logic [8:0] len);
        seq_item_t it;
        it = random_item();
        it.mode = MODE_START;
        it.read_not_write = rnw;
        it.slave_address = addr;
        it.transfer_length = len;
        return it;
    endfunction

    function automatic seq_item_t irq_item(input logic [7:0] status);
        seq_item_t it;
        it = random_item();
        it.mode = MODE_IRQ;
        it.interrupt_pending = 1'b1;
        it.status_code = status;
        return it;
    endfunction

    function automatic seq_item_t load_item(input logic [7:0] idx, input logic [7:0] data);
        seq_item_t it;
        it = random_item();
        it.mode = MODE_LOAD;
        it.buffer_index = idx;
        it.buffer_byte = data;
        return it;
    endfunction

    task automatic queue_item(input seq_item_t it);
        pending_items.push_back(it);
        items_queued++;
    endtask

    // interrupt within a transfer, now and then disturbed
    task automatic queue_irq(input logic [7:0] status);
        seq_item_t it;
        int        pick;
        pick = $urandom_range(99);
        if (pick < 3)
        begin
            it = random_item();
            it.interrupt_pending = 1'b0;
            queue_item(it);
        end
        else if (pick < 6)
            queue_item(load_item(8'($urandom_range(255)), 8'($urandom_range(255))));
        else if (pick < 8)
            queue_item(random_item());
        pick = $urandom_range(99);
        if (pick < 2)
            status = ST_RA_NACK;
        else if (pick < 4)
            status = ST_WA_NACK;
        else if (pick < 5)
            status = 8'($urandom_range(255));
        queue_item(irq_item(status));
    endtask

    // complete read or write transfer with random content
    task automatic queue_transfer();
        logic rnw;
        int   len;
        int   k;
        rnw = 1'($urandom_range(1));
        len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(4);
        queue_item(start_item(rnw, 7'($urandom_range(127)), 9'(len)));
        queue_irq(ST_START_SENT);
        if (rnw)
        begin
            queue_irq(ST_RA_ACK);
            for (k = 0; k < len - 1; k++)
                queue_irq(ST_RD_ACK);
            queue_irq(ST_RD_NACK);
        end
        else
        begin
            queue_irq(ST_WA_ACK);
            for (k = 0; k < len; k++)
                queue_irq(ST_WD_ACK);
        end
    endtask

    task automatic queue_random(input int count);
        int target;
        int pick;
        target = items_queued + count;
        while (items_queued < target)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
                queue_transfer();
            else if (pick < 80)
                queue_item(load_item(8'($urandom_range(255)), 8'($urandom_range(255))));
            else
                queue_item(random_item());
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // sender: presents queued items, predicts each one taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(sequence_step(cur_item));
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {6'd0, cur_item.data_now, cur_item.control_now,
                                cur_item.status_code, cur_item.interrupt_pending,
                                cur_item.buffer_byte, cur_item.buffer_index,
                                cur_item.transfer_length, cur_item.slave_address,
                                cur_item.read_not_write};
                    s_tuser <= cur_item.mode;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_result = m_tdata[37:0];
            if (expected_results.size() == 0)
            begin
                $error("result item %h arrived with none expected", m_tdata);
                error_count++;
            end
            else
            begin
                want_result = expected_results.pop_front();
                check_field("control_write", 32'(want_result.control_write),
                            32'(got_result.control_write));
                check_field("control_value", 32'(want_result.control_value),
                            32'(got_result.control_value));
                check_field("data_write", 32'(want_result.data_write),
                            32'(got_result.data_write));
                check_field("data_value", 32'(want_result.data_value),
                            32'(got_result.data_value));
                check_field("received_valid", 32'(want_result.received_valid),
                            32'(got_result.received_valid));
                check_field("received_byte", 32'(want_result.received_byte),
                            32'(got_result.received_byte));
                check_field("received_index", 32'(want_result.received_index),
                            32'(got_result.received_index));
                check_field("done_res", 32'(want_result.done_res),
                            32'(got_result.done_res));
                check_field("result_code", 32'(want_result.result_code),
                            32'(got_result.result_code));
            end
        end
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("testbench: errors");
        $finish;
    end

    // stimulus and phases
    initial
    begin
        int k;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // whole write buffer filled before any transmit read
        for (k = 0; k < BUF_DEPTH; k++)
            queue_item(load_item(8'(k), 8'($urandom_range(255))));

        // directed: idle interrupt, no interrupt, unused mode
        queue_item(irq_item(8'($urandom_range(255))));
        dir_item = irq_item(ST_START_SENT);
        dir_item.interrupt_pending = 1'b0;
        queue_item(dir_item);
        dir_item = random_item();
        dir_item.mode = 2'd3;
        queue_item(dir_item);
        queue_item(load_item(8'hFF, 8'hFF));
        queue_item(load_item(8'h00, 8'h00));
        // write of two bytes, full control byte
        dir_item = start_item(1'b0, 7'h7F, 9'd2);
        dir_item.control_now = 8'hFF;
        queue_item(dir_item);
        queue_item(irq_item(ST_START_SENT));
        queue_item(irq_item(ST_WA_ACK));
        queue_item(irq_item(ST_WD_ACK));
        queue_item(irq_item(ST_WD_ACK));
        // read of one byte, empty control byte
        dir_item = start_item(1'b1, 7'h00, 9'd1);
        dir_item.control_now = 8'h00;
        queue_item(dir_item);
        queue_item(irq_item(ST_START_SENT));
        queue_item(irq_item(ST_RA_ACK));
        queue_item(irq_item(ST_RD_NACK));
        // zero-length write ends on the address acknowledge
        queue_item(start_item(1'b0, 7'h55, 9'd0));
        queue_item(irq_item(ST_WA_ACK));
        // start while busy, then no reply on write
        queue_item(start_item(1'b1, 7'h2A, 9'd3));
        queue_item(irq_item(ST_RA_ACK));
        queue_item(start_item(1'b0, 7'h11, 9'd511));
        queue_item(irq_item(ST_WA_NACK));
        // no reply on read, then unexpected codes
        queue_item(start_item(1'b1, 7'h33, 9'd256));
        queue_item(irq_item(ST_RA_NACK));
        queue_item(start_item(1'b1, 7'h44, 9'd2));
        queue_item(irq_item(8'h00));
        queue_item(start_item(1'b0, 7'h66, 9'd2));
        queue_item(irq_item(8'hF8));

        // no idling
        queue_random(65);
        wait_drained();
        // sender idle
        send_idle_pct = 63;
        queue_random(65);
        wait_drained();
        // receiver stalling
        send_idle_pct = 0;
        recv_stall_pct = 63;
        queue_random(65);
        wait_drained();
        // both sides
        send_idle_pct = 19;
        recv_stall_pct = 19;
        queue_random(65);
        wait_drained();

        repeat (8) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
